// File: sv/radial_vignette_pixel_unit_defines.svh
// ----------------------------------------------------------------------------
// Radial vignette pixel unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef RADIAL_VIGNETTE_PIXEL_UNIT_DEFINES_SVH
`define RADIAL_VIGNETTE_PIXEL_UNIT_DEFINES_SVH

// same-cycle implication
`define RVP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// invariant
`define RVP_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

// File: sv/rvp_pkg.sv
// ----------------------------------------------------------------------------
// Radial vignette pixel unit: package
// Field widths, register indexes, effect codes and the controller command set.
// ----------------------------------------------------------------------------
`default_nettype none

package rvp_pkg;

  localparam int PIX_W   = 8;
  localparam int CFG_W   = 13;
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 2;
  localparam int CFG_MAX = 2 ** CFG_W - 1;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic [INDEX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [INDEX_W-1:0] REG_MODE   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_DARKEN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LIGHTEN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PASS    = 2'd2;

  typedef struct packed {
    logic load;
    logic sqx;
    logic sqy;
    logic root_step;
    logic square;
    logic mul;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/radial_vignette_pixel_unit.sv
// ----------------------------------------------------------------------------
// Radial vignette pixel unit: top level
// Quadratic radial darken, lighten or pass of a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | red_in, green_in, blue_in
//  out     | out_valid / out_stall| red_out, green_out, blue_out, frame_end
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One pixel is in flight at a time, paced by the one-bit-per-cycle square
//  root of CW = clog2(min(MAX_DIM, 8191)) bits (12 at MAX_DIM = 4096) and the
//  eight-step quotient lanes.
//  A finished result sits in the output register; the next pixel is taken
//  while it waits, and only a second finished result waits for out_stall.
//  rst is synchronous; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_vignette_pixel_unit #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rvp_pkg::PIX_W-1:0]      red_in,
  input  wire logic [rvp_pkg::PIX_W-1:0]      green_in,
  input  wire logic [rvp_pkg::PIX_W-1:0]      blue_in,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [rvp_pkg::PIX_W-1:0]      red_out,
  output logic      [rvp_pkg::PIX_W-1:0]      green_out,
  output logic      [rvp_pkg::PIX_W-1:0]      blue_out,
  output logic                                frame_end,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rvp_pkg::INDEX_W-1:0]    cfg_index,
  input  wire logic [rvp_pkg::CFG_W-1:0]      cfg_data
);
  import rvp_pkg::*;

  localparam int EFF_MAX = (MAX_DIM < CFG_MAX) ? MAX_DIM : CFG_MAX;
  localparam int CW      = $clog2(EFF_MAX);

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  rvp_ctrl #(
    .ROOT_STEPS (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rvp_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .frame_end (frame_end)
  );

endmodule

`default_nettype wire

// File: sv/rvp_datapath.sv
// ----------------------------------------------------------------------------
// Radial vignette pixel unit: datapath
// Frame counters, registers, squares, bit-serial root and three quotient lanes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radial_vignette_pixel_unit_defines.svh"

module rvp_datapath #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rvp_pkg::cmd_t                  cmd,
  input  wire logic                           cfg_we,
  input  wire logic [rvp_pkg::INDEX_W-1:0]    cfg_index,
  input  wire logic [rvp_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic [rvp_pkg::PIX_W-1:0]      red_in,
  input  wire logic [rvp_pkg::PIX_W-1:0]      green_in,
  input  wire logic [rvp_pkg::PIX_W-1:0]      blue_in,
  output logic      [rvp_pkg::PIX_W-1:0]      red_out,
  output logic      [rvp_pkg::PIX_W-1:0]      green_out,
  output logic      [rvp_pkg::PIX_W-1:0]      blue_out,
  output logic                                frame_end
);
  import rvp_pkg::*;

  localparam int EFF_MAX = (MAX_DIM < CFG_MAX) ? MAX_DIM : CFG_MAX;
  localparam int CW      = $clog2(EFF_MAX);
  localparam int EW      = $clog2(EFF_MAX + 1);
  localparam int SW      = 2 * CW;
  localparam int NW      = SW + PIX_W;

  // configuration
  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic [MODE_W-1:0] effect_mode;

  // frame position
  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;

  logic [EW-1:0] eff_w;
  logic [EW-1:0] eff_h;
  logic [CW-1:0] xc;
  logic [CW-1:0] yc;
  logic          col_last;
  logic          row_last;

  // item working registers
  logic [PIX_W-1:0] pix [3];
  logic [CW-1:0]    dx;
  logic [CW-1:0]    dy;
  logic             fe;
  logic [SW-1:0]    acc;
  logic [SW-1:0]    big;
  logic [SW-1:0]    rad;
  logic [CW-1:0]    rem;
  logic [CW-1:0]    root;
  logic [SW-1:0]    d2;
  logic [NW-1:0]    num [3];
  logic [SW-1:0]    drem [3];
  logic [PIX_W-1:0] nlo [3];
  logic [PIX_W-1:0] quo [3];

  logic [CW+1:0]    rem_t;
  logic [CW+1:0]    trial;
  logic             root_ge;
  logic             bypass;

  function automatic logic [EW-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [EW-1:0] r;
    if (v == '0) begin
      r = EW'(1);
    end else if (v > CFG_W'(EFF_MAX)) begin
      r = EW'(EFF_MAX);
    end else begin
      r = EW'(v);
    end
    return r;
  endfunction

  assign eff_w    = eff_dim(image_width);
  assign eff_h    = eff_dim(image_height);
  assign xc       = CW'(eff_w >> 1);
  assign yc       = CW'(eff_h >> 1);
  assign col_last = (EW'(column_count) + EW'(1)) == eff_w;
  assign row_last = (EW'(row_count) + EW'(1)) == eff_h;

  assign rem_t   = {rem, rad[SW-1 -: 2]};
  assign trial   = {root, 2'b01};
  assign root_ge = rem_t >= trial;

  assign bypass = (big == '0) ||
                  ((effect_mode != MODE_DARKEN) && (effect_mode != MODE_LIGHTEN));

  // configuration and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(1);
      image_height <= CFG_W'(1);
      effect_mode  <= MODE_PASS;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH: begin
          image_width  <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
        REG_HEIGHT: begin
          image_height <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
        REG_MODE: begin
          effect_mode <= cfg_data[MODE_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (cmd.load) begin
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_last ? '0 : row_count + CW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // arithmetic sequence
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix[0] <= red_in;
      pix[1] <= green_in;
      pix[2] <= blue_in;
      dx     <= (column_count >= xc) ? column_count - xc : xc - column_count;
      dy     <= (row_count >= yc) ? row_count - yc : yc - row_count;
      fe     <= col_last && row_last;
    end
    if (cmd.sqx) begin
      acc <= SW'(dx) * SW'(dx);
      big <= SW'(xc) * SW'(xc);
    end
    if (cmd.sqy) begin
      rad  <= acc + SW'(dy) * SW'(dy);
      big  <= big + SW'(yc) * SW'(yc);
      rem  <= '0;
      root <= '0;
    end
    // one root bit per step, two radicand bits consumed
    if (cmd.root_step) begin
      rem  <= root_ge ? CW'(rem_t - trial) : CW'(rem_t);
      root <= CW'({root, root_ge});
      rad  <= rad << 2;
    end
    if (cmd.square) begin
      d2 <= SW'(root) * SW'(root);
    end
    for (int k = 0; k < 3; k++) begin
      if (cmd.mul) begin
        if (effect_mode == MODE_DARKEN) begin
          num[k] <= NW'(pix[k]) * NW'(big - d2);
        end else begin
          num[k] <= NW'(PIX_MAX - pix[k]) * NW'(d2);
        end
      end
      // quotient fits in eight bits, so the top of the product is already below big
      if (cmd.div_init) begin
        drem[k] <= num[k][NW-1:PIX_W];
        nlo[k]  <= num[k][PIX_W-1:0];
        quo[k]  <= '0;
      end
      if (cmd.div_step) begin
        if ({drem[k], nlo[k][PIX_W-1]} >= {1'b0, big}) begin
          drem[k] <= SW'({drem[k], nlo[k][PIX_W-1]} - {1'b0, big});
          quo[k]  <= {quo[k][PIX_W-2:0], 1'b1};
        end else begin
          drem[k] <= SW'({drem[k], nlo[k][PIX_W-1]});
          quo[k]  <= {quo[k][PIX_W-2:0], 1'b0};
        end
        nlo[k] <= nlo[k] << 1;
      end
    end
    if (cmd.out_load) begin
      frame_end <= fe;
      if (bypass) begin
        red_out   <= pix[0];
        green_out <= pix[1];
        blue_out  <= pix[2];
      end else if (effect_mode == MODE_LIGHTEN) begin
        red_out   <= pix[0] + quo[0];
        green_out <= pix[1] + quo[1];
        blue_out  <= pix[2] + quo[2];
      end else begin
        red_out   <= quo[0];
        green_out <= quo[1];
        blue_out  <= quo[2];
      end
    end
  end

  `RVP_ASSERT_ALWAYS(a_col_in_frame, EW'(column_count) < eff_w, "column count left the frame")
  `RVP_ASSERT_ALWAYS(a_row_in_frame, EW'(row_count) < eff_h, "row count left the frame")

endmodule

`default_nettype wire

// File: sv/rvp_ctrl.sv
// ----------------------------------------------------------------------------
// Radial vignette pixel unit: controller
// Sequences one pixel through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radial_vignette_pixel_unit_defines.svh"

module rvp_ctrl #(
  parameter int ROOT_STEPS = 12
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rvp_pkg::cmd_t      cmd
);
  import rvp_pkg::*;

  localparam int MAX_STEPS = (ROOT_STEPS > PIX_W) ? ROOT_STEPS : PIX_W;
  localparam int CNT_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_ROOT,
    S_SQR,
    S_MUL,
    S_DINIT,
    S_DIV,
    S_HOLD
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load      = in_valid;
      S_SQX:   cmd.sqx       = 1'b1;
      S_SQY:   cmd.sqy       = 1'b1;
      S_ROOT:  cmd.root_step = 1'b1;
      S_SQR:   cmd.square    = 1'b1;
      S_MUL:   cmd.mul       = 1'b1;
      S_DINIT: cmd.div_init  = 1'b1;
      S_DIV:   cmd.div_step  = 1'b1;
      S_HOLD:  cmd.out_load  = !out_valid || !out_stall;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SQX;
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          state <= S_ROOT;
          cnt   <= CNT_W'(ROOT_STEPS - 1);
        end
        S_ROOT: begin
          if (cnt == '0) state <= S_SQR;
          else cnt <= cnt - CNT_W'(1);
        end
        S_SQR: state <= S_MUL;
        S_MUL: state <= S_DINIT;
        S_DINIT: begin
          state <= S_DIV;
          cnt   <= CNT_W'(PIX_W - 1);
        end
        S_DIV: begin
          if (cnt == '0) state <= S_HOLD;
          else cnt <= cnt - CNT_W'(1);
        end
        S_HOLD: begin
          if (cmd.out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RVP_ASSERT_NEXT(a_single_item, cmd.load, !cmd.load, "pixel accepted while one is in flight")
  `RVP_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_valid || !out_stall, "result overwritten")
  `RVP_ASSERT_NEXT(a_load_sets_valid, cmd.out_load, out_valid, "loaded result not offered")

endmodule

`default_nettype wire
